// File: sv/glnk_pkg.sv
// Shared types, codes and constants for the Gauss linking number block.
package glnk_pkg;

  localparam int unsigned CRD_W  = 24;
  localparam int unsigned IDX_W  = 8;
  localparam int unsigned ENT_W  = 3 * CRD_W;
  localparam int unsigned DEPTH  = 256;
  localparam int unsigned MUL_W  = 33;
  localparam int unsigned PROD_W = 2 * MUL_W;

  localparam logic [28:0] INV_FOUR_PI_Q32 = 29'd341782638;
  localparam logic [63:0] BIG64 = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);

  typedef logic [1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_FIRST_START  = 2'd0;
  localparam cfg_idx_t CFG_FIRST_END    = 2'd1;
  localparam cfg_idx_t CFG_SECOND_START = 2'd2;
  localparam cfg_idx_t CFG_SECOND_END   = 2'd3;

  localparam logic CMD_LOAD    = 1'b0;
  localparam logic CMD_COMPUTE = 1'b1;

  typedef logic [4:0] op_t;
  localparam op_t OP_DX2    = 5'd0;
  localparam op_t OP_DY2    = 5'd1;
  localparam op_t OP_DZ2    = 5'd2;
  localparam op_t OP_A1B2   = 5'd3;
  localparam op_t OP_A2B1   = 5'd4;
  localparam op_t OP_A2B0   = 5'd5;
  localparam op_t OP_A0B2   = 5'd6;
  localparam op_t OP_A0B1   = 5'd7;
  localparam op_t OP_A1B0   = 5'd8;
  localparam op_t OP_DC0_LO = 5'd9;
  localparam op_t OP_DC0_HI = 5'd10;
  localparam op_t OP_DC1_LO = 5'd11;
  localparam op_t OP_DC1_HI = 5'd12;
  localparam op_t OP_DC2_LO = 5'd13;
  localparam op_t OP_DC2_HI = 5'd14;
  localparam op_t OP_S0Q0   = 5'd15;
  localparam op_t OP_S0Q1   = 5'd16;
  localparam op_t OP_S1Q0   = 5'd17;
  localparam op_t OP_S1Q1   = 5'd18;
  localparam op_t OP_FIN_LO = 5'd19;
  localparam op_t OP_FIN_HI = 5'd20;

  typedef enum logic [3:0] {
    ST_IDLE, ST_READ, ST_PREP, ST_MUL, ST_CHECK, ST_SQRT, ST_DIVINIT,
    ST_DIV, ST_ACC, ST_NEXT, ST_FINI, ST_RES
  } state_t;

  function automatic logic signed [CRD_W-1:0] crd(input logic [ENT_W-1:0] e,
                                                  input int unsigned k);
    logic signed [CRD_W-1:0] v;
    v = e[ENT_W-1-k*CRD_W -: CRD_W];
    return v;
  endfunction

endpackage

// File: sv/glnk_in_if.sv
// Request channel carrying load and compute items.
interface glnk_in_if;
  import glnk_pkg::*;
  logic                    valid;
  logic                    ready;
  logic                    cmd;
  logic [IDX_W-1:0]        residue_index;
  logic signed [CRD_W-1:0] coord_x;
  logic signed [CRD_W-1:0] coord_y;
  logic signed [CRD_W-1:0] coord_z;
  modport source (output valid, cmd, residue_index, coord_x, coord_y, coord_z, input ready);
  modport sink (input valid, cmd, residue_index, coord_x, coord_y, coord_z, output ready);
endinterface

// File: sv/glnk_out_if.sv
// Result channel carrying linking number results.
interface glnk_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] link_value;
  logic               degenerate;
  logic               saturated;
  modport source (output valid, link_value, degenerate, saturated, input ready);
  modport sink (input valid, link_value, degenerate, saturated, output ready);
endinterface

// File: sv/glnk_mul.sv
// Shared signed multiplier with registered product.
module glnk_mul (
  input  logic                                clk,
  input  logic signed [glnk_pkg::MUL_W-1:0]   a,
  input  logic signed [glnk_pkg::MUL_W-1:0]   b,
  output logic signed [glnk_pkg::PROD_W-1:0]  p
);
  import glnk_pkg::*;

  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule

// File: sv/gauss_linking_number_segments.sv
// Discrete Gauss linking number between two residue chain segments.
// A load request writes one residue's coordinates. A compute
// request walks every bond pair of the two segments through one shared
// 33x33 multiplier, a two-bit-per-cycle square root and a one-bit-per-cycle
// divider; the root takes 42 steps and the divide 110 steps per bond pair
// (both are skipped when the midpoints coincide), and the sum is then scaled
// by 1/(4*pi). The block takes no request while computing.
module gauss_linking_number_segments (
  input  logic                    clk,
  input  logic                    rst_n,
  glnk_in_if.sink                 in_if,
  glnk_out_if.source              out_if,
  input  logic                    cfg_we,
  input  glnk_pkg::cfg_idx_t      cfg_index,
  input  logic [7:0]              cfg_data
);
  import glnk_pkg::*;

  state_t state_r, state_nxt, ret_r, ret_nxt;
  logic [IDX_W-1:0] fs_r, fe_r, ss_r, se_r, fs_nxt, fe_nxt, ss_nxt, se_nxt;
  logic [IDX_W-1:0] i_r, j_r, i_nxt, j_nxt;
  logic [2:0] rcnt_r, rcnt_nxt;
  logic [ENT_W-1:0] ent_r [4];
  logic [ENT_W-1:0] ent_nxt [4];
  logic signed [25:0] dv_r [3];
  logic signed [25:0] dv_nxt [3];
  logic signed [24:0] a_r [3];
  logic signed [24:0] a_nxt [3];
  logic signed [24:0] b_r [3];
  logic signed [24:0] b_nxt [3];
  logic signed [50:0] c_r [3];
  logic signed [50:0] c_nxt [3];
  logic [51:0] s_r, s_nxt;
  logic signed [79:0] n_r, n_nxt;
  op_t op_r, op_nxt, end_r, end_nxt, pop_r, pop_nxt;
  logic pend_r, pend_nxt;
  logic [83:0] rad_r, rad_nxt;
  logic [41:0] root_r, root_nxt;
  logic [43:0] srem_r, srem_nxt;
  logic [6:0] cnt_r, cnt_nxt;
  logic [109:0] num_r, num_nxt;
  logic [93:0] drem_r, drem_nxt;
  logic [63:0] quo_r, quo_nxt;
  logic ovf_r, ovf_nxt, negn_r, negn_nxt;
  logic [95:0] wide_r, wide_nxt;
  logic signed [63:0] acc_r, acc_nxt;
  logic [63:0] mag_r, mag_nxt;
  logic degen_r, degen_nxt, sat_r, sat_nxt;
  logic ov_r, ov_nxt, odeg_r, odeg_nxt, osat_r, osat_nxt;
  logic [31:0] olink_r, olink_nxt;

  logic [ENT_W-1:0] mem [DEPTH];
  logic [ENT_W-1:0] rd_data_r;
  logic [IDX_W-1:0] rd_addr;
  logic             mem_we;

  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic signed [PROD_W-1:0] mul_p;
  logic [95:0]              pz;
  logic signed [79:0]       px;

  logic [45:0]  sq_rem2, sq_trial;
  logic [94:0]  dv_rem2, dv_den;
  logic [79:0]  nmag;
  logic [62:0]  tmag;
  logic signed [63:0] term;
  logic signed [64:0] sum65;
  logic [8:0]   in_idx, jn_idx;
  logic         start_ok, i_ok, j_ok;
  logic [59:0]  res60;
  logic         in_acc;

  glnk_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p(mul_p));

  assign in_acc        = in_if.valid && in_if.ready;
  assign in_if.ready   = (state_r == ST_IDLE);
  assign mem_we        = in_acc && (in_if.cmd == CMD_LOAD);
  assign out_if.valid      = ov_r;
  assign out_if.link_value = olink_r;
  assign out_if.degenerate = odeg_r;
  assign out_if.saturated  = osat_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[in_if.residue_index] <= {in_if.coord_x, in_if.coord_y, in_if.coord_z};
    end
    rd_data_r <= mem[rd_addr];
  end

  always_comb begin
    case (rcnt_r)
      3'd0:    rd_addr = i_r;
      3'd1:    rd_addr = i_r + 1'b1;
      3'd2:    rd_addr = j_r;
      default: rd_addr = j_r + 1'b1;
    endcase
  end

  // multiplier operand selection
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (state_r == ST_MUL && op_r <= end_r) begin
      case (op_r)
        OP_DX2:    begin mul_a = 33'(dv_r[0]); mul_b = 33'(dv_r[0]); end
        OP_DY2:    begin mul_a = 33'(dv_r[1]); mul_b = 33'(dv_r[1]); end
        OP_DZ2:    begin mul_a = 33'(dv_r[2]); mul_b = 33'(dv_r[2]); end
        OP_A1B2:   begin mul_a = 33'(a_r[1]); mul_b = 33'(b_r[2]); end
        OP_A2B1:   begin mul_a = 33'(a_r[2]); mul_b = 33'(b_r[1]); end
        OP_A2B0:   begin mul_a = 33'(a_r[2]); mul_b = 33'(b_r[0]); end
        OP_A0B2:   begin mul_a = 33'(a_r[0]); mul_b = 33'(b_r[2]); end
        OP_A0B1:   begin mul_a = 33'(a_r[0]); mul_b = 33'(b_r[1]); end
        OP_A1B0:   begin mul_a = 33'(a_r[1]); mul_b = 33'(b_r[0]); end
        OP_DC0_LO: begin mul_a = 33'(dv_r[0]); mul_b = {7'b0, c_r[0][25:0]}; end
        OP_DC0_HI: begin mul_a = 33'(dv_r[0]); mul_b = 33'($signed(c_r[0][50:26])); end
        OP_DC1_LO: begin mul_a = 33'(dv_r[1]); mul_b = {7'b0, c_r[1][25:0]}; end
        OP_DC1_HI: begin mul_a = 33'(dv_r[1]); mul_b = 33'($signed(c_r[1][50:26])); end
        OP_DC2_LO: begin mul_a = 33'(dv_r[2]); mul_b = {7'b0, c_r[2][25:0]}; end
        OP_DC2_HI: begin mul_a = 33'(dv_r[2]); mul_b = 33'($signed(c_r[2][50:26])); end
        OP_S0Q0:   begin mul_a = {7'b0, s_r[25:0]};  mul_b = {12'b0, root_r[20:0]};  end
        OP_S0Q1:   begin mul_a = {7'b0, s_r[25:0]};  mul_b = {12'b0, root_r[41:21]}; end
        OP_S1Q0:   begin mul_a = {7'b0, s_r[51:26]}; mul_b = {12'b0, root_r[20:0]};  end
        OP_S1Q1:   begin mul_a = {7'b0, s_r[51:26]}; mul_b = {12'b0, root_r[41:21]}; end
        OP_FIN_LO: begin mul_a = {1'b0, mag_r[31:0]};  mul_b = {4'b0, INV_FOUR_PI_Q32}; end
        OP_FIN_HI: begin mul_a = {1'b0, mag_r[63:32]}; mul_b = {4'b0, INV_FOUR_PI_Q32}; end
        default:   begin mul_a = '0; mul_b = '0; end
      endcase
    end
  end

  assign pz  = {30'b0, mul_p};
  assign px  = {{14{mul_p[PROD_W-1]}}, mul_p};

  assign sq_rem2  = {srem_r, rad_r[83:82]};
  assign sq_trial = {2'b0, root_r, 2'b01};
  assign dv_rem2  = {drem_r, num_r[109]};
  assign dv_den   = {1'b0, wide_r[93:0]};
  assign nmag     = n_r[79] ? 80'(-n_r) : 80'(n_r);
  assign tmag     = (ovf_r || quo_r[63]) ? BIG64[62:0] : quo_r[62:0];
  assign term     = negn_r ? -$signed({1'b0, tmag}) : $signed({1'b0, tmag});
  assign sum65    = {acc_r[63], acc_r} + {term[63], term};
  assign in_idx   = {1'b0, i_r} + 9'd1;
  assign jn_idx   = {1'b0, j_r} + 9'd1;
  assign start_ok = (fs_r < fe_r) && (fs_r < LAST_IDX) && (ss_r < se_r) && (ss_r < LAST_IDX);
  assign i_ok     = (in_idx < {1'b0, fe_r}) && (in_idx < {1'b0, LAST_IDX});
  assign j_ok     = (jn_idx < {1'b0, se_r}) && (jn_idx < {1'b0, LAST_IDX});
  assign res60    = wide_r[91:32];

  always_comb begin
    state_nxt = state_r;  ret_nxt = ret_r;
    fs_nxt = fs_r;  fe_nxt = fe_r;  ss_nxt = ss_r;  se_nxt = se_r;
    i_nxt = i_r;  j_nxt = j_r;  rcnt_nxt = rcnt_r;
    ent_nxt = ent_r;  dv_nxt = dv_r;  a_nxt = a_r;  b_nxt = b_r;  c_nxt = c_r;
    s_nxt = s_r;  n_nxt = n_r;  op_nxt = op_r;  end_nxt = end_r;
    pop_nxt = op_r;  pend_nxt = 1'b0;
    rad_nxt = rad_r;  root_nxt = root_r;  srem_nxt = srem_r;  cnt_nxt = cnt_r;
    num_nxt = num_r;  drem_nxt = drem_r;  quo_nxt = quo_r;  ovf_nxt = ovf_r;
    negn_nxt = negn_r;  wide_nxt = wide_r;  acc_nxt = acc_r;  mag_nxt = mag_r;
    degen_nxt = degen_r;  sat_nxt = sat_r;
    ov_nxt = ov_r && !out_if.ready;
    odeg_nxt = odeg_r;  osat_nxt = osat_r;  olink_nxt = olink_r;

    if (cfg_we) begin
      case (cfg_index)
        CFG_FIRST_START:  fs_nxt = cfg_data;
        CFG_FIRST_END:    fe_nxt = cfg_data;
        CFG_SECOND_START: ss_nxt = cfg_data;
        CFG_SECOND_END:   se_nxt = cfg_data;
        default:          fs_nxt = fs_r;
      endcase
    end

    case (state_r)
      ST_IDLE: begin
        if (in_acc && in_if.cmd == CMD_COMPUTE) begin
          acc_nxt = '0;
          degen_nxt = 1'b0;
          sat_nxt = 1'b0;
          i_nxt = fs_r;
          j_nxt = ss_r;
          rcnt_nxt = '0;
          state_nxt = start_ok ? ST_READ : ST_FINI;
        end
      end
      ST_READ: begin
        rcnt_nxt = rcnt_r + 3'd1;
        if (rcnt_r != 3'd0) begin
          ent_nxt[rcnt_r[1:0] - 2'd1] = rd_data_r;
        end
        if (rcnt_r == 3'd4) begin
          state_nxt = ST_PREP;
        end
      end
      ST_PREP: begin
        for (int k = 0; k < 3; k++) begin
          dv_nxt[k] = (26'(crd(ent_r[0], k)) + 26'(crd(ent_r[1], k)))
                    - (26'(crd(ent_r[2], k)) + 26'(crd(ent_r[3], k)));
          a_nxt[k] = 25'(crd(ent_r[1], k)) - 25'(crd(ent_r[0], k));
          b_nxt[k] = 25'(crd(ent_r[3], k)) - 25'(crd(ent_r[2], k));
        end
        s_nxt = '0;
        op_nxt = OP_DX2;
        end_nxt = OP_A1B0;
        ret_nxt = ST_CHECK;
        state_nxt = ST_MUL;
      end
      ST_MUL: begin
        if (op_r <= end_r) begin
          pend_nxt = 1'b1;
          op_nxt = op_r + 5'd1;
        end
        if (pend_r) begin
          case (pop_r)
            OP_DX2, OP_DY2, OP_DZ2: s_nxt = s_r + mul_p[51:0];
            OP_A1B2:   c_nxt[0] = mul_p[50:0];
            OP_A2B1:   c_nxt[0] = c_r[0] - mul_p[50:0];
            OP_A2B0:   c_nxt[1] = mul_p[50:0];
            OP_A0B2:   c_nxt[1] = c_r[1] - mul_p[50:0];
            OP_A0B1:   c_nxt[2] = mul_p[50:0];
            OP_A1B0:   c_nxt[2] = c_r[2] - mul_p[50:0];
            OP_DC0_LO, OP_DC1_LO, OP_DC2_LO: n_nxt = n_r + px;
            OP_DC0_HI, OP_DC1_HI, OP_DC2_HI: n_nxt = n_r + (px <<< 26);
            OP_S0Q0:   wide_nxt = wide_r + pz;
            OP_S0Q1:   wide_nxt = wide_r + (pz << 21);
            OP_S1Q0:   wide_nxt = wide_r + (pz << 26);
            OP_S1Q1:   wide_nxt = wide_r + (pz << 47);
            OP_FIN_LO: wide_nxt = wide_r + pz;
            OP_FIN_HI: wide_nxt = wide_r + (pz << 32);
            default:   wide_nxt = wide_r;
          endcase
          if (pop_r == end_r) begin
            state_nxt = ret_r;
          end
        end
      end
      ST_CHECK: begin
        if (s_r == '0) begin
          degen_nxt = 1'b1;
          state_nxt = ST_NEXT;
        end else begin
          n_nxt = '0;
          rad_nxt = {s_r, 32'b0};
          root_nxt = '0;
          srem_nxt = '0;
          cnt_nxt = 7'd41;
          op_nxt = OP_DC0_LO;
          end_nxt = OP_DC2_HI;
          ret_nxt = ST_SQRT;
          state_nxt = ST_MUL;
        end
      end
      ST_SQRT: begin
        rad_nxt = rad_r << 2;
        if (sq_rem2 >= sq_trial) begin
          srem_nxt = 44'(sq_rem2 - sq_trial);
          root_nxt = {root_r[40:0], 1'b1};
        end else begin
          srem_nxt = sq_rem2[43:0];
          root_nxt = {root_r[40:0], 1'b0};
        end
        cnt_nxt = cnt_r - 7'd1;
        if (cnt_r == '0) begin
          wide_nxt = '0;
          op_nxt = OP_S0Q0;
          end_nxt = OP_S1Q1;
          ret_nxt = ST_DIVINIT;
          state_nxt = ST_MUL;
        end
      end
      ST_DIVINIT: begin
        negn_nxt = n_r[79];
        num_nxt = {nmag[75:0], 34'b0};
        drem_nxt = '0;
        quo_nxt = '0;
        ovf_nxt = 1'b0;
        cnt_nxt = 7'd109;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        num_nxt = num_r << 1;
        ovf_nxt = ovf_r | quo_r[63];
        if (dv_rem2 >= dv_den) begin
          drem_nxt = 94'(dv_rem2 - dv_den);
          quo_nxt = {quo_r[62:0], 1'b1};
        end else begin
          drem_nxt = dv_rem2[93:0];
          quo_nxt = {quo_r[62:0], 1'b0};
        end
        cnt_nxt = cnt_r - 7'd1;
        if (cnt_r == '0) begin
          state_nxt = ST_ACC;
        end
      end
      ST_ACC: begin
        if (ovf_r || quo_r[63]) begin
          sat_nxt = 1'b1;
        end
        if (sum65 > $signed({1'b0, BIG64})) begin
          acc_nxt = $signed(BIG64);
          sat_nxt = 1'b1;
        end else if (sum65 < -$signed({1'b0, BIG64})) begin
          acc_nxt = -$signed(BIG64);
          sat_nxt = 1'b1;
        end else begin
          acc_nxt = sum65[63:0];
        end
        state_nxt = ST_NEXT;
      end
      ST_NEXT: begin
        rcnt_nxt = '0;
        if (j_ok) begin
          j_nxt = jn_idx[7:0];
          state_nxt = ST_READ;
        end else if (i_ok) begin
          i_nxt = in_idx[7:0];
          j_nxt = ss_r;
          state_nxt = ST_READ;
        end else begin
          state_nxt = ST_FINI;
        end
      end
      ST_FINI: begin
        mag_nxt = acc_r[63] ? 64'(-acc_r) : 64'(acc_r);
        wide_nxt = '0;
        op_nxt = OP_FIN_LO;
        end_nxt = OP_FIN_HI;
        ret_nxt = ST_RES;
        state_nxt = ST_MUL;
      end
      ST_RES: begin
        if (!ov_r || out_if.ready) begin
          ov_nxt = 1'b1;
          odeg_nxt = degen_r;
          osat_nxt = sat_r;
          if (!acc_r[63]) begin
            if (res60 > 60'h7FFF_FFFF) begin
              olink_nxt = 32'h7FFF_FFFF;
              osat_nxt = 1'b1;
            end else begin
              olink_nxt = res60[31:0];
            end
          end else begin
            if (res60 > 60'h8000_0000) begin
              olink_nxt = 32'h8000_0000;
              osat_nxt = 1'b1;
            end else begin
              olink_nxt = 32'(-res60[31:0]);
            end
          end
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      fs_r <= '0;
      fe_r <= '0;
      ss_r <= '0;
      se_r <= '0;
      pend_r <= 1'b0;
      acc_r <= '0;
      ov_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      fs_r <= fs_nxt;
      fe_r <= fe_nxt;
      ss_r <= ss_nxt;
      se_r <= se_nxt;
      pend_r <= pend_nxt;
      acc_r <= acc_nxt;
      ov_r <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ret_r <= ret_nxt;
    i_r <= i_nxt;
    j_r <= j_nxt;
    rcnt_r <= rcnt_nxt;
    ent_r <= ent_nxt;
    dv_r <= dv_nxt;
    a_r <= a_nxt;
    b_r <= b_nxt;
    c_r <= c_nxt;
    s_r <= s_nxt;
    n_r <= n_nxt;
    op_r <= op_nxt;
    end_r <= end_nxt;
    pop_r <= pop_nxt;
    rad_r <= rad_nxt;
    root_r <= root_nxt;
    srem_r <= srem_nxt;
    cnt_r <= cnt_nxt;
    num_r <= num_nxt;
    drem_r <= drem_nxt;
    quo_r <= quo_nxt;
    ovf_r <= ovf_nxt;
    negn_r <= negn_nxt;
    wide_r <= wide_nxt;
    mag_r <= mag_nxt;
    degen_r <= degen_nxt;
    sat_r <= sat_nxt;
    odeg_r <= odeg_nxt;
    osat_r <= osat_nxt;
    olink_r <= olink_nxt;
  end

endmodule
